/* design/crcfr_pkg.sv */
// Package for the CRC-16 framed setpoint receiver.
// Frame constants, the frame word struct and the byte-wise CRC-16/MODBUS update.
// No dependencies.
package crcfr_pkg;

    localparam logic [7:0]  HDR0_BYTE       = 8'h01;
    localparam logic [7:0]  HDR1_BYTE       = 8'h04;
    localparam logic [7:0]  HDR2_BYTE       = 8'h06;
    localparam logic [3:0]  FRAME_LEN       = 4'd11;
    localparam logic [3:0]  HDR_LEN         = 4'd3;
    localparam logic [3:0]  CRC_END         = 4'd9;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [22:0] MAX_POWER_RESET = 23'd6553500;
    localparam logic [6:0]  POWER_SCALE     = 7'd100;
    localparam logic [3:0]  VI_SCALE        = 4'd10;

    typedef struct packed {
        logic [15:0] power;
        logic [15:0] volt_word;
        logic [15:0] curr_word;
    } frame_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] val;
        case (pos)
            2'd0:    val = HDR0_BYTE;
            2'd1:    val = HDR1_BYTE;
            2'd2:    val = HDR2_BYTE;
            default: val = HDR0_BYTE;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/crcfr_frame_parser.sv */
// Frame hunter: header match, running CRC, payload capture and CRC check.
// Emits checked frame words into a held frame register. Uses crcfr_pkg.
module crcfr_frame_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_accept,
    input  logic [7:0]           byte_data,
    input  logic                 frame_ready,
    output logic                 frame_valid,
    output crcfr_pkg::frame_t    frame
);
    import crcfr_pkg::*;

    logic [3:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  payload_reg [8];
    logic        frame_valid_reg, frame_valid_next;
    frame_t      frame_reg, frame_next;
    logic        pay_we;
    logic [2:0]  pay_idx;
    logic        crc_good;

    assign pay_idx  = 3'(count_reg - HDR_LEN);
    assign crc_good = ({byte_data, payload_reg[6]} == crc_reg);

    always_comb
    begin
        count_next       = count_reg;
        crc_next         = crc_reg;
        pay_we           = 1'b0;
        frame_valid_next = frame_valid_reg && !frame_ready;
        frame_next       = frame_reg;
        if (byte_accept)
        begin
            if (count_reg < HDR_LEN)
            begin
                if (byte_data == hdr_byte(count_reg[1:0]))
                begin
                    crc_next   = crc_update(crc_reg, byte_data);
                    count_next = count_reg + 4'd1;
                end
                else
                begin
                    count_next = '0;
                    crc_next   = CRC_INIT;
                end
            end
            else if (count_reg >= FRAME_LEN)
            begin
                count_next = '0;
                crc_next   = CRC_INIT;
            end
            else
            begin
                pay_we = 1'b1;
                if (count_reg < CRC_END)
                begin
                    crc_next = crc_update(crc_reg, byte_data);
                end
                if (count_reg == FRAME_LEN - 4'd1)
                begin
                    count_next = '0;
                    crc_next   = CRC_INIT;
                    if (crc_good)
                    begin
                        frame_valid_next     = 1'b1;
                        frame_next.power     = {payload_reg[0], payload_reg[1]};
                        frame_next.volt_word = {payload_reg[2], payload_reg[3]};
                        frame_next.curr_word = {payload_reg[4], payload_reg[5]};
                    end
                end
                else
                begin
                    count_next = count_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            crc_reg         <= CRC_INIT;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            crc_reg         <= crc_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        if (pay_we)
        begin
            payload_reg[pay_idx] <= byte_data;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

/* design/crcfr_result_stage.sv */
// Result stage: scaling, power change detect, saturation and output register.
// Holds max_power and last_power. Uses crcfr_pkg.
module crcfr_result_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [22:0]          cfg_wdata,
    input  logic                 frame_valid,
    input  crcfr_pkg::frame_t    frame,
    output logic                 frame_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          set_power,
    output logic [15:0]          voltage,
    output logic [15:0]          current,
    output logic                 power_changed,
    output logic [22:0]          issued_power
);
    import crcfr_pkg::*;

    logic [22:0] max_power_reg;
    logic [15:0] last_power_reg;
    logic        out_valid_reg;
    logic [15:0] set_power_reg, voltage_reg, current_reg;
    logic        changed_reg;
    logic [22:0] issued_reg;
    logic        take;
    logic        changed;
    logic [22:0] power_x100;
    logic [19:0] volt_x10, curr_x10;
    logic [22:0] issued_next;

    assign frame_ready = !out_valid_reg || out_ready;
    assign take        = frame_valid && frame_ready;

    assign power_x100 = 23'(frame.power * POWER_SCALE);
    assign volt_x10   = 20'(frame.volt_word * VI_SCALE);
    assign curr_x10   = 20'(frame.curr_word * VI_SCALE);
    assign changed    = (frame.power != last_power_reg);

    always_comb
    begin
        issued_next = '0;
        if (changed)
        begin
            issued_next = (power_x100 > max_power_reg) ? max_power_reg : power_x100;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_power_reg  <= MAX_POWER_RESET;
            last_power_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_power_reg <= cfg_wdata;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
                if (changed)
                begin
                    last_power_reg <= frame.power;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            set_power_reg <= frame.power;
            voltage_reg   <= volt_x10[15:0];
            current_reg   <= curr_x10[15:0];
            changed_reg   <= changed;
            issued_reg    <= issued_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign set_power     = set_power_reg;
    assign voltage       = voltage_reg;
    assign current       = current_reg;
    assign power_changed = changed_reg;
    assign issued_power  = issued_reg;

endmodule

/* design/crc16_framed_setpoint_receiver_core.sv */
// Top level of the CRC-16/MODBUS framed setpoint receiver.
// A frame's last byte request passes the frame register, then the output register, before its result is on m_axis.
// Throughput: one byte request per cycle while s_axis_tready is high; one result per good 11-byte frame.
// Stalls only while both the frame register and the output register are full.
// Reset: hunt restarts, CRC to 0xFFFF, last power 0, max_power 6553500.
// Instantiates crcfr_frame_parser and crcfr_result_stage; uses crcfr_pkg.
module crc16_framed_setpoint_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [22:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [15:0] set_power, [31:16] voltage,
                                        // [47:32] current, [70:48] issued_power, [71] zero
    output logic        m_axis_tuser    // [0] power_changed
);
    import crcfr_pkg::*;

    logic        byte_accept;
    logic        frame_valid;
    logic        frame_ready;
    frame_t      frame;
    logic [15:0] set_power, voltage, current;
    logic [22:0] issued_power;

    assign s_axis_tready = !frame_valid || frame_ready;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    crcfr_frame_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .byte_data   (s_axis_tdata),
        .frame_ready (frame_ready),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    crcfr_result_stage u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .frame_valid   (frame_valid),
        .frame         (frame),
        .frame_ready   (frame_ready),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .set_power     (set_power),
        .voltage       (voltage),
        .current       (current),
        .power_changed (m_axis_tuser),
        .issued_power  (issued_power)
    );

    assign m_axis_tdata = {1'b0, issued_power, current, voltage, set_power};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (frame_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a full output path");

    a_issued_zero_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (issued_power == 23'd0))
        else $error("issued power nonzero without power change");

    a_issued_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ({1'b0, issued_power} <= 24'(set_power * POWER_SCALE)))
        else $error("issued power exceeds power times 100");

    a_frame_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready) |=> m_axis_tvalid)
        else $error("frame taken but no result registered");

endmodule

/* sim/crc16_framed_setpoint_receiver_core_tb.sv */
// Testbench for crc16_framed_setpoint_receiver_core: byte stream in, setpoint results out.
// Frames are built here with their CRC; a scoreboard class predicts each result.
// Depends on crcfr_pkg and the core RTL only.
`timescale 1ns / 1ps

module crc16_framed_setpoint_receiver_core_tb;
    import crcfr_pkg::*;

    typedef struct packed {
        logic [15:0] power;
        logic [15:0] volt;
        logic [15:0] curr;
        logic        changed;
        logic [22:0] issued;
    } setpoint_t;

    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_HDR, FRAME_SHORT} frame_fault_t;

    class setpoint_scoreboard;
        logic [22:0] max_power;
        logic [3:0]  byte_count;
        logic [15:0] crc;
        logic [7:0]  body [8];
        logic [15:0] last_power;
        setpoint_t   pending_setpoints [$];
        int          mismatches;
        int          good_frames;
        int          bad_crc_frames;
        int          power_changes;
        int          clipped;

        function new();
            max_power = MAX_POWER_RESET;
            byte_count = '0;
            crc = CRC_INIT;
            last_power = '0;
            mismatches = 0;
            good_frames = 0;
            bad_crc_frames = 0;
            power_changes = 0;
            clipped = 0;
        endfunction

        // bit-serial CRC-16/MODBUS, one data bit per shift
        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++)
            begin
                fb = c[0] ^ b[i];
                c = c >> 1;
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void note_request(logic [7:0] b);
            logic [7:0]  hdr;
            logic [15:0] rx_crc;
            logic [15:0] pw;
            logic [31:0] scaled;
            setpoint_t   sp;
            if (byte_count < HDR_LEN)
            begin
                hdr = (byte_count == 0) ? HDR0_BYTE : (byte_count == 1) ? HDR1_BYTE : HDR2_BYTE;
                if (b != hdr)
                begin
                    byte_count = '0;
                    crc = CRC_INIT;
                end
                else
                begin
                    crc = crc_step(crc, b);
                    byte_count = byte_count + 4'd1;
                end
                return;
            end
            if (byte_count >= FRAME_LEN)
            begin
                byte_count = '0;
                crc = CRC_INIT;
                return;
            end
            body[3'(byte_count - HDR_LEN)] = b;
            if (byte_count < CRC_END)
                crc = crc_step(crc, b);
            byte_count = byte_count + 4'd1;
            if (byte_count != FRAME_LEN)
                return;
            rx_crc = {body[7], body[6]};
            if (rx_crc == crc)
            begin
                pw = {body[0], body[1]};
                sp.power = pw;
                sp.volt = 16'({body[2], body[3]} * 10);
                sp.curr = 16'({body[4], body[5]} * 10);
                sp.changed = 1'b0;
                sp.issued = '0;
                if (pw != last_power)
                begin
                    scaled = pw * 100;
                    sp.changed = 1'b1;
                    if (scaled > max_power)
                    begin
                        sp.issued = max_power;
                        clipped++;
                    end
                    else
                        sp.issued = scaled[22:0];
                    last_power = pw;
                    power_changes++;
                end
                pending_setpoints.push_back(sp);
                good_frames++;
            end
            else
                bad_crc_frames++;
            byte_count = '0;
            crc = CRC_INIT;
        endfunction

        function void check_result(logic [71:0] data, logic flag);
            setpoint_t want;
            setpoint_t got;
            got.power = data[15:0];
            got.volt = data[31:16];
            got.curr = data[47:32];
            got.issued = data[70:48];
            got.changed = flag;
            if (pending_setpoints.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result power=%h volt=%h curr=%h chg=%b issued=%0d",
                             $realtime, got.power, got.volt, got.curr, got.changed, got.issued);
                return;
            end
            want = pending_setpoints.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp power=%h volt=%h curr=%h chg=%b issued=%0d",
                             $realtime, want.power, want.volt, want.curr, want.changed,
                             want.issued,
                             " / got power=%h volt=%h curr=%h chg=%b issued=%0d",
                             got.power, got.volt, got.curr, got.changed, got.issued);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [22:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;

    setpoint_scoreboard book;
    int request_count;
    int burst_left;
    int hold_requests;
    int holds_served;
    int hold_left;
    int stall_mode;
    int rx_cycle;

    crc16_framed_setpoint_receiver_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: changing stall pattern plus a long hold-off whenever one is requested
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_requests > holds_served)
        begin
            holds_served++;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= rx_cycle[3];
                default: m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        request_count++;
        book.note_request(b);
    endtask

    task automatic send_frame(input logic [15:0] pw, input logic [15:0] vw,
                              input logic [15:0] cw, input frame_fault_t fault);
        logic [7:0]  f [11];
        logic [15:0] crc;
        int          n;
        int          pos;
        f[0] = HDR0_BYTE;
        f[1] = HDR1_BYTE;
        f[2] = HDR2_BYTE;
        f[3] = pw[15:8];
        f[4] = pw[7:0];
        f[5] = vw[15:8];
        f[6] = vw[7:0];
        f[7] = cw[15:8];
        f[8] = cw[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 9; i++)
            crc = book.crc_step(crc, f[i]);
        f[9] = crc[7:0];
        f[10] = crc[15:8];
        n = 11;
        case (fault)
            FRAME_BAD_CRC:
            begin
                pos = $urandom_range(3, 10);
                f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_BAD_HDR:
            begin
                pos = $urandom_range(0, 2);
                f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
            end
            FRAME_SHORT: n = $urandom_range(1, 10);
            default: ;
        endcase
        for (int i = 0; i < n; i++)
            send_byte(f[i]);
    endtask

    // sender waits until every expected result is out, then lets the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (book.pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limit(input logic [22:0] lim);
        cfg_we <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.max_power = lim;
    endtask

    task automatic random_traffic(input int nbytes, input int nresults);
        int          start_bytes;
        int          start_good;
        int          pick;
        logic [15:0] pw;
        start_bytes = request_count;
        start_good = book.good_frames;
        while (request_count - start_bytes < nbytes || book.good_frames - start_good < nresults)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       pw = book.last_power;
                1:       pw = 16'($urandom_range(0, 655));
                2:       pw = 16'($urandom_range(0, 65535));
                default: pw = 16'(book.max_power / 100 + $urandom_range(0, 2) - 1);
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 14)
                send_frame(pw, 16'($urandom), 16'($urandom), FRAME_GOOD);
            else if (pick < 16)
                send_frame(pw, 16'($urandom), 16'($urandom), FRAME_BAD_CRC);
            else if (pick < 17)
                send_frame(pw, 16'($urandom), 16'($urandom), FRAME_BAD_HDR);
            else if (pick < 18)
                send_frame(pw, 16'($urandom), 16'($urandom), FRAME_SHORT);
            else
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        book = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        request_count = 0;
        burst_left = 0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;
        stall_mode = 0;
        rx_cycle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limit, unchanged and changed power, wrap, bad CRC, header misses
        send_frame(16'h0000, 16'h0000, 16'h0000, FRAME_GOOD);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, FRAME_GOOD);
        send_frame(16'hFFFF, 16'h1999, 16'h199A, FRAME_GOOD);
        send_frame(16'h0001, 16'h8000, 16'h0001, FRAME_GOOD);
        send_frame(16'h0002, 16'h0102, 16'h0304, FRAME_BAD_CRC);
        send_byte(8'h00);
        send_byte(HDR0_BYTE);
        send_byte(8'h05);
        send_byte(HDR0_BYTE);
        send_byte(HDR1_BYTE);
        send_byte(8'h07);
        send_byte(HDR0_BYTE);
        send_byte(HDR0_BYTE);
        send_frame(16'h1234, 16'h5678, 16'h9ABC, FRAME_GOOD);
        drain();
        write_limit(23'd0);
        send_frame(16'h0005, 16'h0001, 16'h0002, FRAME_GOOD);
        drain();

        write_limit(23'($urandom_range(0, 6553500)));
        random_traffic(100, 7);
        drain();
        write_limit(MAX_POWER_RESET);
        hold_requests++;
        random_traffic(100, 7);
        drain();
        write_limit(23'($urandom_range(1000, 100000)));
        random_traffic(100, 7);
        drain();
        write_limit(23'd0);
        random_traffic(100, 7);
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes: %0d good frames, %0d bad-CRC frames dropped.",
                 request_count, book.good_frames, book.bad_crc_frames);
        $display("Power changes %0d, %0d of them clipped at the configured maximum.",
                 book.power_changes, book.clipped);
        if (book.mismatches == 0 && book.pending_setpoints.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
